// ===== rtl/core/lod_pkg.sv =====
// Shared types, constants and register indexes of the obstacle avoidance decider.
package lod_pkg;

   // Default scan length and fixed field widths
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int CFG_IDX_W       = 10;
   localparam int RANGE_W         = 16;
   localparam int SUM_W           = 26;
   localparam int STEP_W          = 20;
   localparam int DEN_W           = 26;
   localparam int IDX_W           = 14;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 20;

   // Angle and rate constants
   localparam logic [22:0] TWO_PI_URAD      = 23'd6283185;
   localparam logic [15:0] QUARTER_PI_MRAD  = 16'd785;
   localparam logic [15:0] HALF_PI_MRAD     = 16'd1571;
   localparam int          SWERVE_BIAS_MRAD = 200;
   localparam int          MM_PER_M         = 1000;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_FRONT_FIRST = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRONT_LAST  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_NEAR_FIRST  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_NEAR_LAST   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SIDE_WIDTH  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_PROX    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_FWD_SPEED   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_INDEX_STEP  = 3'd7;

   // Motion choices
   typedef enum logic [1:0] {
      CH_FORWARD = 2'd0,
      CH_STOP    = 2'd1,
      CH_LEFT    = 2'd2,
      CH_RIGHT   = 2'd3
   } choice_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_sample;
      logic               last_sample;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                motion_choice;
      logic signed [RANGE_W-1:0] turn_rate_mrad_s;
      logic [RANGE_W-1:0]        linear_speed_mm_s;
   } rsp_payload_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic track;
      logic decide;
      logic fold;
      logic num;
      logic div_step;
      logic finish;
      logic load_out;
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_div;
      logic out_free;
   } ctl_status_type;

   // Log2 helper for derived widths
   function automatic int clog2_f(input int value);
      int result;
      result = 0;
      while ((1 << result) < value) result = result + 1;
      return result;
   endfunction

endpackage

// ===== rtl/core/lod_ctrl.sv =====
// Controller state machine that sequences per-sample tracking and the end-of-scan decision.
module lod_ctrl
   import lod_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   output logic           req_ready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   localparam int PW    = clog2_f(MAX_SAMPLES);
   localparam int NUM_W = PW + STEP_W + RANGE_W + 1;
   localparam int CNT_W = clog2_f(NUM_W + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PROD, S_DECIDE, S_FOLD, S_NUM, S_DIV, S_FIN, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.track = 1'b1;
               if (req_last) state_in = S_PROD;
            end
         end
         S_PROD: state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = status.need_div ? S_NUM : S_FIN;
         end
         S_NUM: begin
            cmd.num  = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/lod_datapath.sv =====
// Datapath: configuration registers, window trackers, decision logic, divider and result register.
module lod_datapath
   import lod_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_payload,
   input  logic                  csr_valid,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload,
   input  ctl_cmd_type           cmd,
   output ctl_status_type        status
);

   localparam int PW    = clog2_f(MAX_SAMPLES);
   localparam int TH_W  = PW + STEP_W;
   localparam int NUM_W = TH_W + RANGE_W + 1;
   localparam int RW    = NUM_W + 3;
   localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
   localparam logic signed [RW-1:0] SAT_LO = -RW'(32768);

   // Configuration registers
   logic [CFG_IDX_W-1:0] front_first_ff, front_last_ff, near_first_ff, near_last_ff;
   logic [CFG_IDX_W-1:0] side_width_ff;
   logic [RANGE_W-1:0]   min_prox_ff, fwd_speed_ff;
   logic [STEP_W-1:0]    index_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_first_ff <= 10'd170;
         front_last_ff  <= 10'd190;
         near_first_ff  <= 10'd135;
         near_last_ff   <= 10'd225;
         side_width_ff  <= 10'd45;
         min_prox_ff    <= 16'd500;
         fwd_speed_ff   <= 16'd200;
         index_step_ff  <= 20'd17453;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FRONT_FIRST: front_first_ff <= csr_data[CFG_IDX_W-1:0];
            REG_FRONT_LAST:  front_last_ff  <= csr_data[CFG_IDX_W-1:0];
            REG_NEAR_FIRST:  near_first_ff  <= csr_data[CFG_IDX_W-1:0];
            REG_NEAR_LAST:   near_last_ff   <= csr_data[CFG_IDX_W-1:0];
            REG_SIDE_WIDTH:  side_width_ff  <= csr_data[CFG_IDX_W-1:0];
            REG_MIN_PROX:    min_prox_ff    <= csr_data[RANGE_W-1:0];
            REG_FWD_SPEED:   fwd_speed_ff   <= csr_data[RANGE_W-1:0];
            REG_INDEX_STEP:  index_step_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Per-scan trackers
   logic [PW-1:0]      pos_ff, pos_in;
   logic [RANGE_W-1:0] front_min_ff, front_min_in, near_min_ff, near_min_in;
   logic [PW-1:0]      near_pos_ff, near_pos_in;
   logic [SUM_W-1:0]   left_sum_ff, left_sum_in, right_sum_ff, right_sum_in;
   logic [RANGE_W-1:0] left_peak_ff, left_peak_in, right_peak_ff, right_peak_in;
   logic [PW-1:0]      left_pos_ff, left_pos_in, right_pos_ff, right_pos_in;

   logic signed [IDX_W-1:0] p_s, ff_s, fl_s, nf_s, nl_s, sw_s;
   logic signed [IDX_W-1:0] lf_s, ll_s, rf_s, rl_s;
   logic [RANGE_W-1:0]      r;

   always_comb begin
      r    = req_payload.range_sample;
      p_s  = signed'(IDX_W'(pos_ff));
      ff_s = signed'(IDX_W'(front_first_ff));
      fl_s = signed'(IDX_W'(front_last_ff));
      nf_s = signed'(IDX_W'(near_first_ff));
      nl_s = signed'(IDX_W'(near_last_ff));
      sw_s = signed'(IDX_W'(side_width_ff));
      lf_s = nl_s + IDX_W'(1);
      ll_s = lf_s + sw_s;
      rl_s = nf_s - IDX_W'(1);
      rf_s = rl_s - sw_s;

      pos_in       = pos_ff;
      front_min_in = front_min_ff;
      near_min_in  = near_min_ff;
      near_pos_in  = near_pos_ff;
      left_sum_in  = left_sum_ff;
      left_peak_in = left_peak_ff;
      left_pos_in  = left_pos_ff;
      right_sum_in = right_sum_ff;
      right_peak_in = right_peak_ff;
      right_pos_in = right_pos_ff;

      if (cmd.track) begin
         pos_in = (pos_ff == PW'(MAX_SAMPLES - 1)) ? '0 : pos_ff + 1'b1;
         // Front window minimum
         if (p_s == ff_s) begin
            front_min_in = r;
         end else if (p_s > ff_s && p_s <= fl_s && r < front_min_ff) begin
            front_min_in = r;
         end
         // Near window minimum and its position
         if (p_s == nf_s) begin
            near_min_in = r;
            near_pos_in = pos_ff;
         end else if (p_s > nf_s && p_s <= nl_s && r < near_min_ff) begin
            near_min_in = r;
            near_pos_in = pos_ff;
         end
         // Left side window
         if (p_s == lf_s) begin
            left_peak_in = r;
            left_pos_in  = pos_ff;
         end else if (p_s > lf_s && p_s < ll_s) begin
            left_sum_in = left_sum_ff + SUM_W'(r);
            if (r > left_peak_ff) begin
               left_peak_in = r;
               left_pos_in  = pos_ff;
            end
         end
         // Right side window
         if (p_s == rf_s) begin
            right_peak_in = r;
            right_pos_in  = pos_ff;
         end else if (p_s > rf_s && p_s < rl_s) begin
            right_sum_in = right_sum_ff + SUM_W'(r);
            if (r > right_peak_ff) begin
               right_peak_in = r;
               right_pos_in  = pos_ff;
            end
         end
      end

      // The scan trackers clear once the decision is made
      if (cmd.finish) begin
         pos_in        = '0;
         front_min_in  = '0;
         near_min_in   = '0;
         near_pos_in   = '0;
         left_sum_in   = '0;
         right_sum_in  = '0;
         left_peak_in  = '0;
         right_peak_in = '0;
         left_pos_in   = '0;
         right_pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         front_min_ff  <= '0;
         near_min_ff   <= '0;
         near_pos_ff   <= '0;
         left_sum_ff   <= '0;
         right_sum_ff  <= '0;
         left_peak_ff  <= '0;
         right_peak_ff <= '0;
         left_pos_ff   <= '0;
         right_pos_ff  <= '0;
      end else begin
         pos_ff        <= pos_in;
         front_min_ff  <= front_min_in;
         near_min_ff   <= near_min_in;
         near_pos_ff   <= near_pos_in;
         left_sum_ff   <= left_sum_in;
         right_sum_ff  <= right_sum_in;
         left_peak_ff  <= left_peak_in;
         right_peak_ff <= right_peak_in;
         left_pos_ff   <= left_pos_in;
         right_pos_ff  <= right_pos_in;
      end
   end

   // Front minimum times side count, for the exact average compare
   logic [CFG_IDX_W-1:0] count;
   logic [SUM_W-1:0]     fc_ff;

   assign count = (side_width_ff >= 10'd2) ? side_width_ff - 1'b1 : '0;

   always_ff @(posedge clock) begin
      fc_ff <= SUM_W'(front_min_ff) * SUM_W'(count);
   end

   // Decision rules
   logic         fa_left, fa_right, right_of_mid, quick;
   logic [17:0]  nr_x, m_x2, m_x3, nr_x2;
   choice_type   cur_choice_ff, ch, choice_ff;
   logic         rom_ff, quick_ff;
   logic [PW-1:0] peak_pos, pos_gap;
   logic [TH_W-1:0]  theta_ff;
   logic [DEN_W-1:0] den_ff;

   always_comb begin
      fa_left  = (count == '0) ? (front_min_ff != '0) : (fc_ff > left_sum_ff);
      fa_right = (count == '0) ? (front_min_ff != '0) : (fc_ff > right_sum_ff);
      right_of_mid = IDX_W'({near_pos_ff, 1'b0}) >
                     (IDX_W'(near_first_ff) + IDX_W'(near_last_ff));
      nr_x  = 18'(near_min_ff);
      nr_x2 = {1'b0, near_min_ff, 1'b0};
      m_x2  = {1'b0, min_prox_ff, 1'b0};
      m_x3  = m_x2 + 18'(min_prox_ff);
      quick = 17'({near_min_ff, 1'b0}) < 17'(fwd_speed_ff);

      ch = cur_choice_ff;
      if (near_min_ff < min_prox_ff) begin
         ch = CH_STOP;
      end else if (fa_left && fa_right) begin
         ch = CH_FORWARD;
      end else if (left_sum_ff != right_sum_ff && nr_x > m_x2) begin
         ch = CH_FORWARD;
      end else if (nr_x2 < m_x3 && near_min_ff > min_prox_ff) begin
         ch = right_of_mid ? CH_RIGHT : CH_LEFT;
      end

      peak_pos = (ch == CH_RIGHT) ? right_pos_ff : left_pos_ff;
      pos_gap  = (peak_pos >= near_pos_ff) ? peak_pos - near_pos_ff : near_pos_ff - peak_pos;
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         choice_ff <= ch;
         rom_ff    <= right_of_mid;
         quick_ff  <= quick;
         theta_ff  <= TH_W'(pos_gap) * TH_W'(index_step_ff);
         den_ff    <= DEN_W'(near_min_ff) * DEN_W'(MM_PER_M);
      end
   end

   // Angle folding into the shorter way round
   logic signed [TH_W+1:0] th_s, alt_s, fold_s;
   logic [TH_W-1:0]        thmag_ff;
   logic                   thneg_ff;

   always_comb begin
      th_s   = signed'((TH_W + 2)'(theta_ff));
      alt_s  = signed'((TH_W + 2)'(TWO_PI_URAD)) - th_s;
      fold_s = (alt_s < th_s) ? alt_s : th_s;
   end

   always_ff @(posedge clock) begin
      if (cmd.fold) begin
         thneg_ff <= fold_s[TH_W+1];
         thmag_ff <= fold_s[TH_W+1] ? TH_W'(-fold_s) : TH_W'(fold_s);
      end
   end

   assign status.need_div = (choice_ff == CH_LEFT || choice_ff == CH_RIGHT) && !quick_ff;

   // Restoring divider, one quotient bit a cycle; the numerator is rounded by half the divisor
   logic [NUM_W-1:0] div_q_ff;
   logic [DEN_W:0]   rem_ff, rem_sh;

   assign rem_sh = {rem_ff[DEN_W-1:0], div_q_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.num) begin
         div_q_ff <= NUM_W'(thmag_ff) * NUM_W'(fwd_speed_ff) + NUM_W'(den_ff >> 1);
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff   <= rem_sh - {1'b0, den_ff};
            div_q_ff <= {div_q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff   <= rem_sh;
            div_q_ff <= {div_q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   // Turn rate for the chosen motion, saturated
   logic signed [RW-1:0]      mag_s, q_s, s_s, rr_s;
   logic signed [RANGE_W-1:0] swerve_rate, rate_sel;
   logic signed [RANGE_W-1:0] held_rate_ff;

   always_comb begin
      mag_s = signed'(RW'(div_q_ff));
      q_s   = thneg_ff ? -mag_s : mag_s;
      s_s   = q_s + RW'(SWERVE_BIAS_MRAD);
      rr_s  = (choice_ff == CH_LEFT) ? s_s : -s_s;
      if (rr_s > SAT_HI) begin
         swerve_rate = 16'sh7FFF;
      end else if (rr_s < SAT_LO) begin
         swerve_rate = 16'sh8000;
      end else begin
         swerve_rate = rr_s[RANGE_W-1:0];
      end

      case (choice_ff)
         CH_STOP: begin
            rate_sel = (rom_ff && cur_choice_ff != CH_STOP) ?
                       -signed'(QUARTER_PI_MRAD) : signed'(QUARTER_PI_MRAD);
         end
         CH_LEFT, CH_RIGHT: begin
            rate_sel = quick_ff ? -signed'(HALF_PI_MRAD) : swerve_rate;
         end
         default: rate_sel = held_rate_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_choice_ff <= CH_STOP;
         held_rate_ff  <= '0;
      end else if (cmd.finish) begin
         cur_choice_ff <= choice_ff;
         held_rate_ff  <= rate_sel;
      end
   end

   // Result register
   logic rsp_valid_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_payload.motion_choice     <= cur_choice_ff;
         rsp_payload.turn_rate_mrad_s  <= held_rate_ff;
         rsp_payload.linear_speed_mm_s <= (cur_choice_ff == CH_STOP) ? '0 : fwd_speed_ff;
      end
   end

endmodule

// ===== rtl/core/lidar_obstacle_avoid_decider_unit.sv =====
// Top level of the lidar obstacle avoidance decider: controller, datapath and checks.
//
//   Channel   Direction  Handshake              Transaction
//   req_      in         req_valid / req_ready  one range sample with last flag
//   rsp_      out        rsp_valid / rsp_ready  decision, turn rate and speed
//   csr_      in         csr_valid / csr_ready  one configuration register write
//
// After a last sample is taken the controller steps through its product, decide, fold and finish
// states, then loads the result for forward, stop or a close-range swerve; a swerve that needs
// the restoring divider adds a load state and one divide step per quotient bit (PW + 37 bits, 47
// at 1024 samples). Synchronous reset returns the configuration, tracker and state registers to
// their defaults and the choice to stop. Samples that are not last are taken while a result
// waits; a new decision waits in its final state until the result register is free.
module lidar_obstacle_avoid_decider_unit
   import lod_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   assign csr_ready = 1'b1;

   lod_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_sample),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lod_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

   // The block stops taking samples once a scan ends
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_sample |=> !req_ready)
      else $error("sample accepted right after the end of a scan");

   // A stopped robot reports no speed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.motion_choice == CH_STOP |-> rsp_payload.linear_speed_mm_s == '0)
      else $error("nonzero speed with a stop decision");

   // A stop always turns by a quarter turn rate one way or the other
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.motion_choice == CH_STOP |->
      (rsp_payload.turn_rate_mrad_s == 16'sd785 || rsp_payload.turn_rate_mrad_s == -16'sd785))
      else $error("stop decision with an unexpected turn rate");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the lidar obstacle avoidance decider: directed and random scans checked against a predictor.
`timescale 1ns / 1ps

module tb;
   import lod_pkg::*;

   // Predicts the decision of each scan and checks the results in order.
   class decision_scoreboard;
      int front_first, front_last, near_first, near_last, side_w;
      longint min_prox, fwd_speed, step_urad;
      int position, near_pos, left_pos, right_pos;
      longint front_min, near_min, left_sum, right_sum, left_peak, right_peak;
      choice_type current_choice, prior_choice;
      longint held_rate;
      rsp_payload_type pending[$];
      int errors, results;

      function new();
         front_first = 170; front_last = 190; near_first = 135; near_last = 225;
         side_w = 45; min_prox = 500; fwd_speed = 200; step_urad = 17453;
         current_choice = CH_STOP; prior_choice = CH_STOP; held_rate = 0;
         errors = 0; results = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         position = 0; near_pos = 0; left_pos = 0; right_pos = 0;
         front_min = 0; near_min = 0; left_sum = 0; right_sum = 0;
         left_peak = 0; right_peak = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_FRONT_FIRST: front_first = val[9:0];
            REG_FRONT_LAST:  front_last = val[9:0];
            REG_NEAR_FIRST:  near_first = val[9:0];
            REG_NEAR_LAST:   near_last = val[9:0];
            REG_SIDE_WIDTH:  side_w = val[9:0];
            REG_MIN_PROX:    min_prox = val[15:0];
            REG_FWD_SPEED:   fwd_speed = val[15:0];
            REG_INDEX_STEP:  step_urad = val;
            default: ;
         endcase
      endfunction

      // Sum and peak over the open interior of a side window; the peak loads at its first position.
      function void track_side(int p, longint r, int first, int last,
                               ref longint sum, ref longint peak, ref int peak_pos);
         if (p == first) begin
            peak = r;
            peak_pos = p;
         end else if (p > first && p < last) begin
            sum = (sum + r) & 64'h3FF_FFFF;
            if (r > peak) begin
               peak = r;
               peak_pos = p;
            end
         end
      endfunction

      function bit front_above(longint sum, longint cnt);
         if (cnt == 0) return front_min > 0;
         return front_min * cnt > sum;
      endfunction

      function longint swerve_rate(int peak_pos, bit go_left);
         longint offset, theta, num, den, q;
         offset = peak_pos - near_pos;
         if (offset < 0) offset = -offset;
         theta = offset * step_urad;
         if (64'sd6283185 - theta < theta) theta = 64'sd6283185 - theta;
         if (2 * near_min < fwd_speed) return -longint'(HALF_PI_MRAD);
         num = theta * fwd_speed;
         den = near_min * MM_PER_M;
         // Round to nearest with ties away from zero.
         if (num >= 0) q = (num + den / 2) / den;
         else q = -((-num + den / 2) / den);
         return go_left ? q + SWERVE_BIAS_MRAD : -(q + SWERVE_BIAS_MRAD);
      endfunction

      function void note_sample(logic [RANGE_W-1:0] range_mm, bit last);
         int p;
         longint r, cnt;
         bit above_left, above_right, right_of_mid;
         choice_type ch;
         longint rate;
         rsp_payload_type exp_rsp;
         p = position;
         r = range_mm;
         if (p == front_first) front_min = r;
         else if (p > front_first && p <= front_last && r < front_min) front_min = r;
         if (p == near_first || (p > near_first && p <= near_last && r < near_min)) begin
            near_min = r;
            near_pos = p;
         end
         track_side(p, r, near_last + 1, near_last + 1 + side_w, left_sum, left_peak, left_pos);
         track_side(p, r, near_first - 1 - side_w, near_first - 1,
                    right_sum, right_peak, right_pos);
         position = (position + 1) % MAX_SAMPLES_DEF;
         if (!last) return;

         // End of scan: pick the motion, then the turn rate.
         cnt = side_w >= 2 ? side_w - 1 : 0;
         above_left = front_above(left_sum, cnt);
         above_right = front_above(right_sum, cnt);
         right_of_mid = 2 * near_pos > near_first + near_last;
         ch = current_choice;
         if (near_min < min_prox) ch = CH_STOP;
         else if (above_left && above_right) ch = CH_FORWARD;
         else if (left_sum != right_sum && near_min > 2 * min_prox) ch = CH_FORWARD;
         else if (2 * near_min < 3 * min_prox && near_min > min_prox)
            ch = right_of_mid ? CH_RIGHT : CH_LEFT;
         current_choice = ch;

         rate = held_rate;
         if (ch == CH_STOP)
            rate = (right_of_mid && prior_choice != CH_STOP) ?
                   -longint'(QUARTER_PI_MRAD) : longint'(QUARTER_PI_MRAD);
         else if (ch == CH_LEFT) rate = swerve_rate(left_pos, 1'b1);
         else if (ch == CH_RIGHT) rate = swerve_rate(right_pos, 1'b0);
         if (rate > 32767) rate = 32767;
         if (rate < -32768) rate = -32768;
         held_rate = rate;
         prior_choice = ch;

         exp_rsp.motion_choice = ch;
         exp_rsp.turn_rate_mrad_s = rate[15:0];
         exp_rsp.linear_speed_mm_s = (ch == CH_STOP) ? 16'd0 : fwd_speed[15:0];
         pending.push_back(exp_rsp);
         clear_scan();
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("tb: unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         results++;
         if (got.motion_choice !== want.motion_choice ||
             got.turn_rate_mrad_s !== want.turn_rate_mrad_s ||
             got.linear_speed_mm_s !== want.linear_speed_mm_s) begin
            errors++;
            if (errors <= 10)
               $display("tb: result %0d mismatch: choice %0d/%0d rate %0d/%0d speed %0d/%0d",
                        results, want.motion_choice, got.motion_choice,
                        $signed(want.turn_rate_mrad_s), $signed(got.turn_rate_mrad_s),
                        want.linear_speed_mm_s, got.linear_speed_mm_s);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   decision_scoreboard board = new();
   bit no_gaps;
   int samples_sent;
   int idle_cycles = 0;

   always #4 clock = ~clock;

   lidar_obstacle_avoid_decider_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Watchdog: ends the run after a long stretch with no transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 5000) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // Result side: random stalls before each transaction.
   initial begin
      int stall;
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         board.check_result(rsp_payload);
      end
   end

   task automatic send_sample(logic [RANGE_W-1:0] range_mm, bit last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload.range_sample <= range_mm;
      req_payload.last_sample <= last;
      do @(posedge clock); while (!req_ready);
      board.note_sample(range_mm, last);
      samples_sent++;
   endtask

   // Lets the block drain so that registers can be written safely.
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic write_all(int ff, int fl, int nf, int nl, int sw, int m, int v, int st);
      wait_idle();
      write_csr(REG_FRONT_FIRST, CSR_DATA_W'(ff));
      write_csr(REG_FRONT_LAST, CSR_DATA_W'(fl));
      write_csr(REG_NEAR_FIRST, CSR_DATA_W'(nf));
      write_csr(REG_NEAR_LAST, CSR_DATA_W'(nl));
      write_csr(REG_SIDE_WIDTH, CSR_DATA_W'(sw));
      write_csr(REG_MIN_PROX, CSR_DATA_W'(m));
      write_csr(REG_FWD_SPEED, CSR_DATA_W'(v));
      write_csr(REG_INDEX_STEP, CSR_DATA_W'(st));
   endtask

   // One scan whose ranges mostly cluster above a multiple of half the proximity limit, else are uniform or extremes.
   task automatic send_scan(int len);
      longint base, r;
      int mode;
      mode = $urandom_range(0, 9);
      base = board.min_prox * $urandom_range(0, 7) / 2;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: r = $urandom_range(0, 65535);
            1: r = ($urandom_range(0, 1) == 1) ? 65535 : 0;
            default: r = base + $urandom_range(0, 3) * board.min_prox / 4;
         endcase
         if (r > 65535) r = 65535;
         send_sample(r[15:0], i == len - 1);
      end
   endtask

   initial begin
      int ff, nf, span;
      samples_sent = 0;
      no_gaps = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: tiny windows, field extremes, reversed windows and empty sides.
      write_all(2, 3, 1, 4, 2, 1000, 65535, 1048575);
      send_sample(16'd0, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      for (int i = 0; i < 7; i++) send_sample(RANGE_W'(1400 + i * 10), i == 6);
      for (int i = 0; i < 7; i++) send_sample(i == 3 ? 16'd1200 : 16'hFFFF, i == 6);
      write_all(5, 1, 4, 2, 0, 65535, 1, 1);
      for (int i = 0; i < 7; i++) send_sample(16'hFFFF, i == 6);
      write_all(3, 5, 2, 6, 1, 1, 300, 500000);
      send_sample(16'd0, 1'b0);
      send_sample(16'd2, 1'b1);

      // One long scan at the top of every range, so the position wraps around.
      write_all(1023, 1023, 1023, 1023, 1023, 65535, 65535, 1048575);
      send_scan(1030);

      // Random settings with small windows so that scans stay short.
      while (samples_sent < 1900) begin
         ff = $urandom_range(0, 20);
         nf = $urandom_range(0, 20);
         write_all(ff, ff + $urandom_range(0, 10) - ($urandom_range(0, 9) == 0 ? 12 : 0),
                   nf, nf + $urandom_range(0, 15), $urandom_range(0, 12),
                   $urandom_range(1, 65535 >> $urandom_range(0, 15)),
                   $urandom_range(1, 65535 >> $urandom_range(0, 15)),
                   $urandom_range(1, 1048575 >> $urandom_range(0, 19)));
         no_gaps = ($urandom_range(0, 3) == 0);
         span = board.near_last + board.side_w + 3;
         repeat (8) send_scan(($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span);
      end
      no_gaps = 1'b0;

      wait_idle();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== lidar_obstacle_avoid_decider_unit.f =====
rtl/core/lod_pkg.sv
rtl/core/lod_ctrl.sv
rtl/core/lod_datapath.sv
rtl/core/lidar_obstacle_avoid_decider_unit.sv
tb/sv/tb.sv
